@@ design/tsa_pkg.sv @@
// Shared constants for the touch sample averager.
// Holds field widths, status codes, register indexes and calibration windows.
// No dependencies; every other design file imports this package.
package tsa_pkg;

  localparam int RAW_W    = 10;
  localparam int OUT_W    = 10;
  localparam int STATUS_W = 2;

  localparam logic [STATUS_W-1:0] STATUS_RELEASED = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FILLING  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_VALID    = 2'd2;

  // Configuration port layout.
  localparam int PADDR_W = 3;
  localparam int IDX_W   = PADDR_W - 2;
  localparam logic [IDX_W-1:0] REG_THRESHOLD = 1'b0;
  localparam logic [RAW_W-1:0] THRESH_RESET  = 10'd940;

  // Default block parameters.
  localparam int DEF_SAMPLE_SHIFT  = 3;
  localparam int DEF_SCREEN_WIDTH  = 240;
  localparam int DEF_SCREEN_HEIGHT = 320;

  // Calibration windows in raw ADC units.
  localparam int WIN_Y_START = 148;
  localparam int WIN_Y_END   = 912;
  localparam int WIN_X_START = 87;
  localparam int WIN_X_END   = 891;
  localparam int WIN_Y_SPAN  = WIN_Y_END - WIN_Y_START;
  localparam int WIN_X_SPAN  = WIN_X_END - WIN_X_START;

  // Output clamp range.
  localparam int OUT_MIN = -128;
  localparam int OUT_MAX = 511;

  // Mapping datapath widths. The scaled magnitude stays below 2^NUM_W for any
  // screen size up to 1024, and the quotient fits Q_W bits for these windows.
  localparam int SCALE_W   = 11;
  localparam int NUM_W     = 20;
  localparam int REC_SHIFT = 20;
  localparam int Q_W       = 11;
  localparam int RES_W     = 13;

endpackage

@@ design/tsa_cell.sv @@
// One cell of the sample chain: holds one raw (x, y) pair.
// Passes its pair to the next cell on a shift and adds it to the running sums.
// Depends on tsa_pkg.
module tsa_cell import tsa_pkg::*; #(
  parameter int SUM_W = RAW_W + DEF_SAMPLE_SHIFT
) (
  input  logic             clk_i,
  input  logic             shift_i,
  input  logic [RAW_W-1:0] x_i,
  input  logic [RAW_W-1:0] y_i,
  output logic [RAW_W-1:0] x_o,
  output logic [RAW_W-1:0] y_o,
  input  logic [SUM_W-1:0] sum_x_i,
  input  logic [SUM_W-1:0] sum_y_i,
  output logic [SUM_W-1:0] sum_x_o,
  output logic [SUM_W-1:0] sum_y_o
);

  logic [RAW_W-1:0] x_q;
  logic [RAW_W-1:0] y_q;

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      x_q <= x_i;
      y_q <= y_i;
    end
  end

  assign x_o     = x_q;
  assign y_o     = y_q;
  assign sum_x_o = sum_x_i + SUM_W'(x_q);
  assign sum_y_o = sum_y_i + SUM_W'(y_q);

endmodule

@@ design/tsa_map.sv @@
// Calibration pipeline for one screen axis: offset, scale, divide, optional flip, clamp.
// The divide by the window span is a reciprocal multiply with one correction.
// Depends on tsa_pkg.
module tsa_map import tsa_pkg::*; #(
  parameter int WIN_START = WIN_Y_START,
  parameter int WIN_SPAN  = WIN_Y_SPAN,
  parameter int SCALE     = DEF_SCREEN_WIDTH,
  parameter bit INVERT    = 1'b0
) (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic [RAW_W-1:0]        avg_i,
  output logic signed [OUT_W-1:0] coord_o
);

  localparam int SPAN_W  = $clog2(WIN_SPAN + 1);
  localparam int RECIP   = (1 << REC_SHIFT) / WIN_SPAN;
  localparam int RECIP_W = $clog2(RECIP + 1);
  localparam int BACK_W  = Q_W + SPAN_W;

  localparam logic signed [RAW_W:0]   START_S = (RAW_W + 1)'(WIN_START);
  localparam logic [SCALE_W-1:0]      SCALE_U = SCALE_W'(SCALE);
  localparam logic [RECIP_W-1:0]      RECIP_U = RECIP_W'(RECIP);
  localparam logic [SPAN_W-1:0]       SPAN_U  = SPAN_W'(WIN_SPAN);
  localparam logic signed [RES_W-1:0] SCALE_S = RES_W'(SCALE);
  localparam logic signed [RES_W-1:0] RES_MIN = RES_W'(OUT_MIN);
  localparam logic signed [RES_W-1:0] RES_MAX = RES_W'(OUT_MAX);

  // Stage a: signed offset, magnitude times the screen size.
  logic signed [RAW_W:0]       diff;
  logic [RAW_W-1:0]            mag;
  logic [RAW_W+SCALE_W-1:0]    prod;
  logic [NUM_W-1:0]            num_a_q;
  logic                        neg_a_q;

  assign diff = $signed({1'b0, avg_i}) - START_S;
  assign mag  = diff[RAW_W] ? RAW_W'(-diff) : diff[RAW_W-1:0];
  assign prod = mag * SCALE_U;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num_a_q <= prod[NUM_W-1:0];
      neg_a_q <= diff[RAW_W];
    end
  end

  // Stage b: quotient estimate, at most one below the true quotient.
  logic [NUM_W+RECIP_W-1:0] est_full;
  logic [Q_W-1:0]           qest_q;
  logic [NUM_W-1:0]         num_b_q;
  logic                     neg_b_q;

  assign est_full = num_a_q * RECIP_U;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      qest_q  <= Q_W'(est_full >> REC_SHIFT);
      num_b_q <= num_a_q;
      neg_b_q <= neg_a_q;
    end
  end

  // Stage c: remainder check fixes the estimate.
  logic [BACK_W-1:0] back;
  logic [BACK_W-1:0] rem;
  logic [Q_W-1:0]    q_q;
  logic              neg_c_q;

  assign back = qest_q * SPAN_U;
  assign rem  = BACK_W'(num_b_q) - back;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      q_q     <= (rem >= BACK_W'(SPAN_U)) ? qest_q + 1'b1 : qest_q;
      neg_c_q <= neg_b_q;
    end
  end

  // Stage d: restore the sign (truncation toward zero), flip, clamp.
  logic signed [RES_W-1:0] q_s;
  logic signed [RES_W-1:0] val;
  logic signed [RES_W-1:0] res;
  logic signed [OUT_W-1:0] coord_q;

  assign q_s = $signed(RES_W'(q_q));
  assign val = neg_c_q ? -q_s : q_s;

  always_comb begin
    if (INVERT) begin
      res = SCALE_S - val;
    end else begin
      res = val;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (res < RES_MIN) begin
        coord_q <= RES_MIN[OUT_W-1:0];
      end else if (res > RES_MAX) begin
        coord_q <= RES_MAX[OUT_W-1:0];
      end else begin
        coord_q <= res[OUT_W-1:0];
      end
    end
  end

  assign coord_o = coord_q;

endmodule

@@ design/touch_sample_averager_top.sv @@
// Touch sample averager: input control, sample chain, two axis mappers.
// Depends on tsa_pkg, tsa_cell and tsa_map.
//
// Usage: each request on the input channel (in_valid_i, raw_x_i, raw_y_i) is a
// raw touch ADC pair. A raw y below the touch threshold register counts as
// touched and is shifted into a chain of 2^SAMPLE_SHIFT cells; a raw y at or
// above it releases the panel and clears the fill count. Every request gives
// exactly one result request: point_status_o (released, filling, valid) with
// screen_x_o and screen_y_o, which are zero unless the status is valid. From
// the (2^SAMPLE_SHIFT + 1)-th consecutive touched pair onward the chain is
// averaged and mapped onto screen coordinates, clamped to -128..511.
// Throughput is one request per cycle unless out_stall_i holds a result. A
// request passes the average register (sums the cell chain) and four mapping
// stages (offset and scale multiply, reciprocal multiply, correction, clamp).
// When out_stall_i holds a waiting result, the whole pipeline freezes and
// in_stall_o rises; no request is lost or repeated. Reset empties the pipeline,
// clears the fill count and sets the threshold to 940; cell contents are not
// cleared, since a valid point is only formed from pairs written after reset.
// The threshold register sits at byte address 0 of the APB port.
module touch_sample_averager_top import tsa_pkg::*; #(
  parameter int SAMPLE_SHIFT  = DEF_SAMPLE_SHIFT,
  parameter int SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
  parameter int SCREEN_HEIGHT = DEF_SCREEN_HEIGHT
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [RAW_W-1:0]        raw_x_i,
  input  logic [RAW_W-1:0]        raw_y_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [STATUS_W-1:0]     point_status_o,
  output logic signed [OUT_W-1:0] screen_x_o,
  output logic signed [OUT_W-1:0] screen_y_o,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [PADDR_W-1:0]      paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  localparam int DEPTH  = 1 << SAMPLE_SHIFT;
  localparam int SUM_W  = RAW_W + SAMPLE_SHIFT;
  localparam int CNT_W  = $clog2(DEPTH + 2);
  localparam int STAGES = 6;
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(DEPTH + 1);

  // Configuration register.
  logic [RAW_W-1:0] thr_q;
  logic [IDX_W-1:0] reg_idx;
  logic             cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[PADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THRESH_RESET;
    end else if (cfg_wr && reg_idx == REG_THRESHOLD) begin
      thr_q <= pwdata[RAW_W-1:0];
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_THRESHOLD: prdata = 32'(thr_q);
      default:       prdata = '0;
    endcase
  end

  // Handshake and pipeline advance.
  logic advance;
  logic accept;
  logic [STAGES-1:0] vld_q;

  assign advance    = !vld_q[STAGES-1] || !out_stall_i;
  assign accept     = in_valid_i && advance;
  assign in_stall_o = !advance;

  // Touch detection and fill count.
  logic                touched;
  logic [CNT_W-1:0]    cnt_q;
  logic [CNT_W-1:0]    cnt_inc;
  logic [STATUS_W-1:0] status_in;

  assign touched = raw_y_i < thr_q;
  assign cnt_inc = (cnt_q == CNT_MAX) ? cnt_q : cnt_q + 1'b1;

  always_comb begin
    if (!touched) begin
      status_in = STATUS_RELEASED;
    end else if (cnt_inc == CNT_MAX) begin
      status_in = STATUS_VALID;
    end else begin
      status_in = STATUS_FILLING;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (accept) begin
      cnt_q <= touched ? cnt_inc : '0;
    end
  end

  // Valid and status travel alongside the datapath.
  logic [STAGES-1:0][STATUS_W-1:0] st_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (advance) begin
      vld_q <= {vld_q[STAGES-2:0], accept};
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      st_q <= {st_q[STAGES-2:0], status_in};
    end
  end

  // Sample chain: new pair enters at cell 0, sums ripple down the row.
  logic [RAW_W-1:0] link_x [DEPTH+1];
  logic [RAW_W-1:0] link_y [DEPTH+1];
  logic [SUM_W-1:0] sum_x  [DEPTH+1];
  logic [SUM_W-1:0] sum_y  [DEPTH+1];
  logic             shift;

  assign shift     = accept && touched;
  assign link_x[0] = raw_x_i;
  assign link_y[0] = raw_y_i;
  assign sum_x[0]  = '0;
  assign sum_y[0]  = '0;

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    tsa_cell #(
      .SUM_W (SUM_W)
    ) u_cell (
      .clk_i   (clk_i),
      .shift_i (shift),
      .x_i     (link_x[g]),
      .y_i     (link_y[g]),
      .x_o     (link_x[g+1]),
      .y_o     (link_y[g+1]),
      .sum_x_i (sum_x[g]),
      .sum_y_i (sum_y[g]),
      .sum_x_o (sum_x[g+1]),
      .sum_y_o (sum_y[g+1])
    );
  end

  // Averages of the chain contents, registered once the cells hold the new pair.
  logic [RAW_W-1:0] avg_x_q;
  logic [RAW_W-1:0] avg_y_q;

  always_ff @(posedge clk_i) begin
    if (advance) begin
      avg_x_q <= sum_x[DEPTH][SUM_W-1:SAMPLE_SHIFT];
      avg_y_q <= sum_y[DEPTH][SUM_W-1:SAMPLE_SHIFT];
    end
  end

  // Screen column follows raw y; screen row follows raw x inversely.
  logic signed [OUT_W-1:0] col;
  logic signed [OUT_W-1:0] row;

  tsa_map #(
    .WIN_START (WIN_Y_START),
    .WIN_SPAN  (WIN_Y_SPAN),
    .SCALE     (SCREEN_WIDTH),
    .INVERT    (1'b0)
  ) u_map_col (
    .clk_i   (clk_i),
    .en_i    (advance),
    .avg_i   (avg_y_q),
    .coord_o (col)
  );

  tsa_map #(
    .WIN_START (WIN_X_START),
    .WIN_SPAN  (WIN_X_SPAN),
    .SCALE     (SCREEN_HEIGHT),
    .INVERT    (1'b1)
  ) u_map_row (
    .clk_i   (clk_i),
    .en_i    (advance),
    .avg_i   (avg_x_q),
    .coord_o (row)
  );

  logic point_ok;

  assign point_ok       = st_q[STAGES-1] == STATUS_VALID;
  assign out_valid_o    = vld_q[STAGES-1];
  assign point_status_o = st_q[STAGES-1];
  assign screen_x_o     = point_ok ? col : '0;
  assign screen_y_o     = point_ok ? row : '0;

  // Checks on the fill count, the pipeline control and the result status.
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_MAX)
    else $error("fill count beyond saturation");

  a_release_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && !touched |=> cnt_q == '0)
    else $error("release did not clear the fill count");

  a_saturate: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && touched && cnt_q == CNT_MAX |=> cnt_q == CNT_MAX)
    else $error("fill count left saturation while touched");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a blocked result");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (point_status_o == STATUS_RELEASED ||
                     point_status_o == STATUS_FILLING ||
                     point_status_o == STATUS_VALID))
    else $error("result carries an unknown status");

endmodule

@@ sim/testbench.sv @@
// Testbench for touch_sample_averager_top: random and directed touch ADC pairs,
// checked against an in-bench model of the averaging ring and screen mapping.
// Depends on tsa_pkg and the design files under design/.
module testbench;
  import tsa_pkg::*;

  localparam int SHIFT      = DEF_SAMPLE_SHIFT;
  localparam int RING_DEPTH = 1 << SHIFT;
  localparam int RUN_MAX    = RING_DEPTH + 1;
  localparam int SCREEN_W   = DEF_SCREEN_WIDTH;
  localparam int SCREEN_H   = DEF_SCREEN_HEIGHT;
  localparam int QUIET_LIMIT = 1000;

  typedef struct packed {
    logic [RAW_W-1:0] x;
    logic [RAW_W-1:0] y;
  } pair_t;

  typedef struct packed {
    logic [STATUS_W-1:0]     status;
    logic signed [OUT_W-1:0] sx;
    logic signed [OUT_W-1:0] sy;
  } point_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    in_valid_i = 1'b0;
  logic                    in_stall_o;
  logic [RAW_W-1:0]        raw_x_i = '0;
  logic [RAW_W-1:0]        raw_y_i = '0;
  logic                    out_valid_o;
  logic                    out_stall_i = 1'b0;
  logic [STATUS_W-1:0]     point_status_o;
  logic signed [OUT_W-1:0] screen_x_o;
  logic signed [OUT_W-1:0] screen_y_o;
  logic                    psel = 1'b0;
  logic                    penable = 1'b0;
  logic                    pwrite = 1'b0;
  logic [PADDR_W-1:0]      paddr = '0;
  logic [31:0]             pwdata = '0;
  logic [31:0]             prdata;
  logic                    pready;

  touch_sample_averager_top dut (.*);

  always #5 clk_i = ~clk_i;

  // Model state: sample ring, write pointer, run length and threshold copy.
  logic [RAW_W-1:0] ring_x [RING_DEPTH];
  logic [RAW_W-1:0] ring_y [RING_DEPTH];
  logic [SHIFT-1:0] wr_slot = '0;
  int               touch_run = 0;
  logic [RAW_W-1:0] touch_thr = THRESH_RESET;

  pair_t  pending_pairs[$];
  point_t expected_points[$];
  int     gen_count = 0;
  int     mismatch_count = 0;
  int     idle_pct = 32;
  int     quiet_cycles = 0;

  function automatic logic signed [OUT_W-1:0] clamp_coord(int v);
    if (v < OUT_MIN) v = OUT_MIN;
    if (v > OUT_MAX) v = OUT_MAX;
    return v[OUT_W-1:0];
  endfunction

  function automatic point_t predict_point(logic [RAW_W-1:0] rx, logic [RAW_W-1:0] ry);
    point_t p;
    int sum_x, sum_y, avg_x, avg_y, col, row;
    p = '0;
    sum_x = 0;
    sum_y = 0;
    if (ry < touch_thr) begin
      ring_x[wr_slot] = rx;
      ring_y[wr_slot] = ry;
      wr_slot = wr_slot + 1'b1;
      if (touch_run < RUN_MAX) touch_run++;
      if (touch_run >= RUN_MAX) begin
        for (int i = 0; i < RING_DEPTH; i++) begin
          sum_x += ring_x[i];
          sum_y += ring_y[i];
        end
        avg_x = sum_x >>> SHIFT;
        avg_y = sum_y >>> SHIFT;
        // Signed integer division truncates toward zero, as the mapping requires.
        col = ((avg_y - WIN_Y_START) * SCREEN_W) / WIN_Y_SPAN;
        row = SCREEN_H - ((avg_x - WIN_X_START) * SCREEN_H) / WIN_X_SPAN;
        p.status = STATUS_VALID;
        p.sx = clamp_coord(col);
        p.sy = clamp_coord(row);
      end else begin
        p.status = STATUS_FILLING;
      end
    end else begin
      touch_run = 0;
      wr_slot = '0;
      p.status = STATUS_RELEASED;
    end
    return p;
  endfunction

  task automatic note_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("mismatch: %s", msg);
  endtask

  // Request driver: holds a stalled request, otherwise pulls the next pair.
  always @(posedge clk_i) begin : drive_pairs
    pair_t nxt;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o)
        expected_points.push_back(predict_point(raw_x_i, raw_y_i));
      if (!in_valid_i || !in_stall_o) begin
        if (pending_pairs.size() != 0 && $urandom_range(99, 0) >= idle_pct) begin
          nxt = pending_pairs.pop_front();
          raw_x_i <= nxt.x;
          raw_y_i <= nxt.y;
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin : check_points
    point_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_points.size() == 0) begin
          note_mismatch($sformatf("unexpected result status=%0d x=%0d y=%0d",
                                  point_status_o, screen_x_o, screen_y_o));
        end else begin
          want = expected_points.pop_front();
          if (point_status_o !== want.status || screen_x_o !== want.sx ||
              screen_y_o !== want.sy)
            note_mismatch($sformatf("expected status=%0d x=%0d y=%0d, got status=%0d x=%0d y=%0d",
                                    want.status, want.sx, want.sy,
                                    point_status_o, screen_x_o, screen_y_o));
        end
      end
      out_stall_i <= ($urandom_range(99, 0) < idle_pct);
    end
  end

  always @(posedge clk_i) begin : watchdog
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || psel) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic push_pair(input logic [RAW_W-1:0] x, input logic [RAW_W-1:0] y);
    pending_pairs.push_back('{x: x, y: y});
    gen_count++;
  endtask

  // One touch burst: a run of touched pairs, usually closed by a release.
  // Short runs cannot reach a valid point on their own; noise mixes both kinds at random.
  task automatic push_burst(input bit with_release);
    int n, kind;
    bit clustered;
    logic [RAW_W-1:0] cx, cy;
    kind = $urandom_range(99, 0);
    if (touch_thr == 0 || kind >= 90) begin
      n = $urandom_range(6, 1);
      repeat (n) push_pair($urandom_range(1023, 0), $urandom_range(1023, 0));
    end else begin
      n = (kind < 70) ? $urandom_range(40, 9) : $urandom_range(8, 1);
      clustered = $urandom_range(1, 0);
      cx = $urandom_range(1023, 0);
      cy = $urandom_range(touch_thr - 1, 0);
      // Clustered runs keep the averages near the window edges as often as the middle.
      repeat (n) begin
        if (clustered)
          push_pair(cx ^ RAW_W'($urandom_range(7, 0)), cy & ~RAW_W'($urandom_range(7, 0)));
        else
          push_pair($urandom_range(1023, 0), $urandom_range(touch_thr - 1, 0));
      end
    end
    if (with_release && $urandom_range(99, 0) < 85)
      push_pair($urandom_range(1023, 0), $urandom_range(1023, touch_thr));
  endtask

  // Checked after the edge so that requests launched at that edge are seen.
  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_pairs.size() != 0 || in_valid_i || expected_points.size() != 0);
  endtask

  task automatic set_threshold(input int val);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {REG_THRESHOLD, 2'b00};
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i);
    while (!pready);
    touch_thr = val[RAW_W-1:0];
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i);
    while (!pready);
    if (prdata[RAW_W-1:0] !== touch_thr)
      note_mismatch($sformatf("threshold readback expected %0d, got %0d",
                              touch_thr, prdata[RAW_W-1:0]));
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  initial begin : stimulus
    int thr_plan [10];
    int thr, goal;
    thr_plan = '{1023, 0, 1, 512, -1, 940, -1, 1023, -1, 2};
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: corner averages at the reset threshold, releases at and above it.
    repeat (9) push_pair(0, 0);
    repeat (8) push_pair(1023, 939);
    push_pair(512, 940);
    push_pair(0, 1023);
    push_pair(1023, 0);
    push_pair(0, 939);
    push_pair(1023, 1023);
    wait_drained();

    // Each phase ends on a burst without a closing release, so a touch run can
    // carry the ring across a threshold change.
    for (int p = 0; p < 10; p++) begin
      thr = (thr_plan[p] < 0) ? $urandom_range(1022, 2) : thr_plan[p];
      set_threshold(thr);
      idle_pct = (p == 3) ? 0 : 32;
      goal = gen_count + ((thr == 0) ? 30 : 100);
      while (gen_count < goal) push_burst(1'b1);
      push_burst(1'b0);
      wait_drained();
    end

    repeat (10) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
